FILE: rtl/assert_macros.svh
// Assertion helpers used by occgm_ctrl. Clock and reset are the block's own port names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define OGM_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("occupancy grid check failed");
`define OGM_NEVER(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("occupancy grid forbidden condition");
`else
`define OGM_ASSERT(name, prop)
`define OGM_NEVER(name, expr)
`endif
`endif

FILE: rtl/occgm_pkg.sv
package occgm_pkg;

  localparam int unsigned GRID_COLS_DEF   = 256;
  localparam int unsigned GRID_ROWS_DEF   = 256;
  localparam int unsigned MAX_INFLATE_DEF = 15;

  localparam int HEIGHT_MARGIN = 50;

  // register reset values
  localparam logic signed [15:0] ORIGIN_X_RST  = -16'sd5000;
  localparam logic signed [15:0] ORIGIN_Y_RST  = -16'sd5000;
  localparam logic [9:0]         CELL_SIZE_RST = 10'd50;
  localparam logic [14:0]        ROI_RST       = 15'd5000;
  localparam logic [14:0]        SELF_CLR_RST  = 15'd500;
  localparam logic [14:0]        LEG_RST       = 15'd250;
  localparam logic signed [15:0] CEILING_RST   = 16'sd1500;
  localparam logic [3:0]         INFLATE_RST   = 4'd7;
  localparam logic signed [15:0] POSE_Z_RST    = 16'sd400;

  // register indexes
  localparam logic [2:0] CFG_ORIGIN_X  = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Y  = 3'd1;
  localparam logic [2:0] CFG_CELL_SIZE = 3'd2;
  localparam logic [2:0] CFG_ROI       = 3'd3;
  localparam logic [2:0] CFG_SELF_CLR  = 3'd4;
  localparam logic [2:0] CFG_LEG       = 3'd5;
  localparam logic [2:0] CFG_CEILING   = 3'd6;
  localparam logic [2:0] CFG_INFLATE   = 3'd7;

  // request types
  localparam logic [2:0] REQ_POSE    = 3'd0;
  localparam logic [2:0] REQ_CLEAR   = 3'd1;
  localparam logic [2:0] REQ_POINT   = 3'd2;
  localparam logic [2:0] REQ_INFLATE = 3'd3;
  localparam logic [2:0] REQ_QUERY   = 3'd4;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ROI      = 3'd1;
  localparam logic [2:0] ST_SELF     = 3'd2;
  localparam logic [2:0] ST_HEIGHT   = 3'd3;
  localparam logic [2:0] ST_OFF_GRID = 3'd4;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic       cell_free;
  } out_t;

  typedef struct packed {
    logic       latch_in;
    logic       pose_load;
    logic       clr_start;
    logic       clr_step;
    logic       div_start;
    logic       stat_set;
    logic [2:0] stat_val;
    logic       free_set;
    logic       mark_wr;
    logic       inf_start;
    logic       inf_rd;
    logic       inf_wr;
    logic       swap;
    logic       out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       div_busy;
    logic [2:0] pt_status;
    logic       in_grid;
    logic       inf_zero;
    logic       dy_last;
    logic       row_last;
  } dp_sts_t;

endpackage

FILE: rtl/occgm_div.sv
module occgm_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [16:0] num_i,
  input  logic [9:0]         den_i,
  output logic               busy_o,
  output logic               neg_o,
  output logic [15:0]        quo_o
);
  // restoring divide on the magnitude, one quotient bit per cycle
  logic        busy_q, neg_q;
  logic [3:0]  cnt_q;
  logic [15:0] mag_q;
  logic [9:0]  rem_q;
  logic [9:0]  den_q;
  logic signed [16:0] num_neg;
  logic [10:0] rem_sh, rem_n;
  logic        ge;

  assign num_neg = -num_i;
  assign rem_sh  = {rem_q, mag_q[15]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_n   = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 4'd1;
      if (cnt_q == 4'd15) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[16];
      mag_q <= num_i[16] ? num_neg[15:0] : num_i[15:0];
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_n[9:0];
      mag_q <= {mag_q[14:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign neg_o  = neg_q;
  assign quo_o  = mag_q;
endmodule

FILE: rtl/occgm_dp.sv
module occgm_dp #(
  parameter int unsigned GRID_COLS   = occgm_pkg::GRID_COLS_DEF,
  parameter int unsigned GRID_ROWS   = occgm_pkg::GRID_ROWS_DEF,
  parameter int unsigned MAX_INFLATE = occgm_pkg::MAX_INFLATE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  occgm_pkg::in_t        in_data_i,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i,
  input  occgm_pkg::ctrl_cmd_t  cmd_i,
  output occgm_pkg::dp_sts_t    sts_o,
  output occgm_pkg::out_t       out_data_o
);
  import occgm_pkg::*;

  localparam int CW  = $clog2(GRID_COLS);
  localparam int RW  = $clog2(GRID_ROWS);
  localparam int RDW = $clog2(MAX_INFLATE + 1);
  localparam int DYW = RDW + 1;
  localparam int SQW = 2 * RDW + 1;
  localparam int KN  = 2 * MAX_INFLATE + 1;
  localparam int SW  = RW + DYW + 1;

  // configuration
  logic signed [15:0] orig_x_q, orig_y_q, ceil_q;
  logic [9:0]         cell_q;
  logic [14:0]        roi_q, self_q, leg_q;
  logic [3:0]         infl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orig_x_q <= ORIGIN_X_RST;
      orig_y_q <= ORIGIN_Y_RST;
      cell_q   <= CELL_SIZE_RST;
      roi_q    <= ROI_RST;
      self_q   <= SELF_CLR_RST;
      leg_q    <= LEG_RST;
      ceil_q   <= CEILING_RST;
      infl_q   <= INFLATE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ORIGIN_X:  orig_x_q <= cfg_data_i;
        CFG_ORIGIN_Y:  orig_y_q <= cfg_data_i;
        CFG_CELL_SIZE: cell_q   <= cfg_data_i[9:0];
        CFG_ROI:       roi_q    <= cfg_data_i[14:0];
        CFG_SELF_CLR:  self_q   <= cfg_data_i[14:0];
        CFG_LEG:       leg_q    <= cfg_data_i[14:0];
        CFG_CEILING:   ceil_q   <= cfg_data_i;
        CFG_INFLATE:   infl_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // request and pose
  logic [2:0]         req_q;
  logic signed [15:0] x_q, y_q, z_q;
  logic signed [15:0] pose_x_q, pose_y_q, pose_z_q;
  logic               pose_known_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      req_q <= in_data_i.req_type;
      x_q   <= in_data_i.coord_x;
      y_q   <= in_data_i.coord_y;
      z_q   <= in_data_i.coord_z;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pose_x_q     <= '0;
      pose_y_q     <= '0;
      pose_z_q     <= POSE_Z_RST;
      pose_known_q <= 1'b0;
    end else if (cmd_i.pose_load) begin
      pose_x_q     <= x_q;
      pose_y_q     <= y_q;
      pose_z_q     <= z_q;
      pose_known_q <= 1'b1;
    end
  end

  // range and height checks, three register stages
  logic signed [16:0] dx_q, dy_q2;
  logic signed [33:0] px, py;
  logic [31:0]        sqx_q, sqy_q;
  logic [29:0]        roi2_q, self2_q;
  logic [32:0]        d2;
  logic               roi_gt_q, self_lt_q, hgt_bad_q;
  logic signed [17:0] lo;

  assign px = dx_q * dx_q;
  assign py = dy_q2 * dy_q2;
  assign d2 = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign lo = 18'(pose_z_q) - 18'($signed({1'b0, leg_q})) + 18'(HEIGHT_MARGIN);

  always_ff @(posedge clk_i) begin
    dx_q      <= 17'(x_q) - 17'(pose_x_q);
    dy_q2     <= 17'(y_q) - 17'(pose_y_q);
    sqx_q     <= px[31:0];
    sqy_q     <= py[31:0];
    roi2_q    <= roi_q * roi_q;
    self2_q   <= self_q * self_q;
    roi_gt_q  <= d2 > {3'b0, roi2_q};
    self_lt_q <= d2 < {3'b0, self2_q};
    hgt_bad_q <= (18'(z_q) < lo) || (z_q > ceil_q);
  end

  // cell index
  logic signed [16:0] offx, offy;
  logic [9:0]         den;
  logic               bx, by, nx, ny;
  logic [15:0]        qx, qy;
  logic               x_ok, y_ok, in_grid;
  logic [CW-1:0]      ix;
  logic [RW-1:0]      iy;

  assign offx = 17'(x_q) - 17'(orig_x_q);
  assign offy = 17'(y_q) - 17'(orig_y_q);
  assign den  = (cell_q == '0) ? 10'd1 : cell_q;

  occgm_div u_div_x (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .num_i(offx), .den_i(den),
    .busy_o(bx), .neg_o(nx), .quo_o(qx)
  );
  occgm_div u_div_y (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .num_i(offy), .den_i(den),
    .busy_o(by), .neg_o(ny), .quo_o(qy)
  );

  // truncation toward zero: a small negative offset still lands in cell 0
  assign x_ok    = (!nx || (qx == '0)) && ({1'b0, qx} < 17'(GRID_COLS));
  assign y_ok    = (!ny || (qy == '0)) && ({1'b0, qy} < 17'(GRID_ROWS));
  assign in_grid = x_ok && y_ok;
  assign ix      = qx[CW-1:0];
  assign iy      = qy[RW-1:0];

  logic [2:0] pt_status;
  always_comb begin
    if (pose_known_q && roi_gt_q)       pt_status = ST_ROI;
    else if (pose_known_q && self_lt_q) pt_status = ST_SELF;
    else if (hgt_bad_q)                 pt_status = ST_HEIGHT;
    else if (!in_grid)                  pt_status = ST_OFF_GRID;
    else                                pt_status = ST_OK;
  end

  // inflation sweep control
  logic [RW-1:0]          oy_q;
  logic signed [DYW-1:0]  dy_q, dyp_q;
  logic [RDW-1:0]         r_q, r_eff;
  logic [SQW-1:0]         r2_q;
  logic                   pend_q;
  logic                   sel_q;
  logic [GRID_COLS-1:0]   acc_q;
  logic signed [SW-1:0]   rsum;
  logic                   rin;
  logic signed [DYW-1:0]  neg_r_eff, neg_r_q;

  always_comb begin
    if (32'(infl_q) > MAX_INFLATE) r_eff = RDW'(MAX_INFLATE);
    else                           r_eff = RDW'(infl_q);
  end
  assign neg_r_eff = -$signed({1'b0, r_eff});
  assign neg_r_q   = -$signed({1'b0, r_q});
  assign rsum      = SW'($signed({1'b0, oy_q})) + SW'(dy_q);
  assign rin       = !rsum[SW-1] && (rsum < $signed(SW'(GRID_ROWS)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oy_q   <= '0;
      dy_q   <= '0;
      pend_q <= 1'b0;
      sel_q  <= 1'b0;
    end else begin
      pend_q <= cmd_i.inf_rd && rin;
      if (cmd_i.swap) sel_q <= ~sel_q;
      if (cmd_i.clr_start) oy_q <= '0;
      else if (cmd_i.clr_step) oy_q <= oy_q + 1'b1;
      if (cmd_i.inf_start) begin
        oy_q <= '0;
        dy_q <= neg_r_eff;
      end else if (cmd_i.inf_rd) begin
        dy_q <= dy_q + 1'b1;
      end else if (cmd_i.inf_wr) begin
        oy_q <= oy_q + 1'b1;
        dy_q <= neg_r_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dyp_q <= dy_q;
    if (cmd_i.inf_start) begin
      r_q  <= r_eff;
      r2_q <= SQW'(r_eff) * SQW'(r_eff);
    end
  end

  // planes, one row per entry
  logic [GRID_COLS-1:0] pl0 [GRID_ROWS];
  logic [GRID_COLS-1:0] pl1 [GRID_ROWS];
  logic [GRID_COLS-1:0] rd0_q, rd1_q, cur_rd, wd, dil;
  logic [RW-1:0]        wa, ra;
  logic                 we0, we1;

  assign cur_rd = sel_q ? rd1_q : rd0_q;
  assign wa     = (cmd_i.clr_step || cmd_i.inf_wr) ? oy_q : iy;
  assign ra     = cmd_i.inf_rd ? rsum[RW-1:0] : iy;
  always_comb begin
    if (cmd_i.clr_step)    wd = '0;
    else if (cmd_i.inf_wr) wd = acc_q;
    else                   wd = cur_rd | (GRID_COLS'(1) << ix);
  end
  assign we0 = (!sel_q && (cmd_i.clr_step || cmd_i.mark_wr)) || (sel_q && cmd_i.inf_wr);
  assign we1 = (sel_q && (cmd_i.clr_step || cmd_i.mark_wr)) || (!sel_q && cmd_i.inf_wr);

  always_ff @(posedge clk_i) begin
    if (we0) pl0[wa] <= wd;
    rd0_q <= pl0[ra];
  end

  always_ff @(posedge clk_i) begin
    if (we1) pl1[wa] <= wd;
    rd1_q <= pl1[ra];
  end

  // one row of the disk: horizontal dilation with offsets inside the radius
  logic [RDW-1:0]  adyp;
  logic [SQW-1:0]  dysq;
  logic [KN-1:0]   mask;
  logic signed [DYW-1:0] dyp_neg;

  assign dyp_neg = -dyp_q;
  assign adyp    = dyp_q[DYW-1] ? dyp_neg[RDW-1:0] : dyp_q[RDW-1:0];
  assign dysq    = SQW'(adyp) * SQW'(adyp);

  always_comb begin
    int k, c, src, dxa;
    for (k = 0; k < KN; k++) begin
      dxa = (k >= int'(MAX_INFLATE)) ? (k - int'(MAX_INFLATE)) : (int'(MAX_INFLATE) - k);
      mask[k] = (SQW'(dxa * dxa) + dysq) <= r2_q;
    end
    dil = '0;
    for (c = 0; c < int'(GRID_COLS); c++) begin
      for (k = 0; k < KN; k++) begin
        src = c - (k - int'(MAX_INFLATE));
        if (src >= 0 && src < int'(GRID_COLS))
          dil[c] = dil[c] | (mask[k] & cur_rd[src]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.inf_start || cmd_i.inf_wr) acc_q <= '0;
    else if (pend_q) acc_q <= acc_q | dil;
  end

  // result
  logic [2:0] stat_q;
  logic       free_q;
  out_t       out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      stat_q <= ST_OK;
      free_q <= 1'b0;
    end else begin
      if (cmd_i.stat_set) stat_q <= cmd_i.stat_val;
      if (cmd_i.free_set) free_q <= ~cur_rd[ix];
    end
    if (cmd_i.out_load) begin
      out_q.status    <= stat_q;
      out_q.cell_free <= free_q;
    end
  end

  assign out_data_o = out_q;

  assign sts_o.req       = req_q;
  assign sts_o.div_busy  = bx || by;
  assign sts_o.pt_status = pt_status;
  assign sts_o.in_grid   = in_grid;
  assign sts_o.inf_zero  = (r_eff == '0);
  assign sts_o.dy_last   = (dy_q == $signed({1'b0, r_q}));
  assign sts_o.row_last  = (oy_q == RW'(GRID_ROWS - 1));
endmodule

FILE: rtl/occgm_ctrl.sv
`include "assert_macros.svh"
module occgm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  occgm_pkg::dp_sts_t   sts_i,
  output occgm_pkg::ctrl_cmd_t cmd_o
);
  import occgm_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DEC     = 4'd1;
  localparam logic [3:0] S_CLR     = 4'd2;
  localparam logic [3:0] S_DIV     = 4'd3;
  localparam logic [3:0] S_MARK_RD = 4'd4;
  localparam logic [3:0] S_MARK_WR = 4'd5;
  localparam logic [3:0] S_QRY_RD  = 4'd6;
  localparam logic [3:0] S_QRY_ANS = 4'd7;
  localparam logic [3:0] S_INF_RD  = 4'd8;
  localparam logic [3:0] S_INF_ACC = 4'd9;
  localparam logic [3:0] S_INF_WR  = 4'd10;
  localparam logic [3:0] S_RESP    = 4'd11;

  logic [3:0] state_q, state_d;
  logic       init_q, init_d;
  logic       out_valid_q;
  ctrl_cmd_t  cmd;

  always_comb begin
    state_d = state_q;
    init_d  = init_q;
    cmd     = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.latch_in = 1'b1;
          state_d      = S_DEC;
        end
      end
      S_DEC: begin
        case (sts_i.req)
          REQ_POSE: begin
            cmd.pose_load = 1'b1;
            state_d       = S_RESP;
          end
          REQ_CLEAR: begin
            cmd.clr_start = 1'b1;
            state_d       = S_CLR;
          end
          REQ_POINT, REQ_QUERY: begin
            cmd.div_start = 1'b1;
            state_d       = S_DIV;
          end
          REQ_INFLATE: begin
            if (sts_i.inf_zero) begin
              state_d = S_RESP;
            end else begin
              cmd.inf_start = 1'b1;
              state_d       = S_INF_RD;
            end
          end
          default: state_d = S_RESP;
        endcase
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts_i.row_last) begin
          init_d  = 1'b0;
          state_d = init_q ? S_IDLE : S_RESP;
        end
      end
      S_DIV: begin
        if (!sts_i.div_busy) begin
          if (sts_i.req == REQ_POINT) begin
            if (sts_i.pt_status != ST_OK) begin
              cmd.stat_set = 1'b1;
              cmd.stat_val = sts_i.pt_status;
              state_d      = S_RESP;
            end else begin
              state_d = S_MARK_RD;
            end
          end else if (!sts_i.in_grid) begin
            cmd.stat_set = 1'b1;
            cmd.stat_val = ST_OFF_GRID;
            state_d      = S_RESP;
          end else begin
            state_d = S_QRY_RD;
          end
        end
      end
      S_MARK_RD: state_d = S_MARK_WR;
      S_MARK_WR: begin
        cmd.mark_wr = 1'b1;
        state_d     = S_RESP;
      end
      S_QRY_RD: state_d = S_QRY_ANS;
      S_QRY_ANS: begin
        cmd.free_set = 1'b1;
        state_d      = S_RESP;
      end
      S_INF_RD: begin
        cmd.inf_rd = 1'b1;
        if (sts_i.dy_last) state_d = S_INF_ACC;
      end
      S_INF_ACC: state_d = S_INF_WR;
      S_INF_WR: begin
        cmd.inf_wr = 1'b1;
        if (sts_i.row_last) begin
          cmd.swap = 1'b1;
          state_d  = S_RESP;
        end else begin
          state_d = S_INF_RD;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // reset starts in the clearing pass over the map
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      init_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      if (cmd.out_load)     out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  `OGM_ASSERT(a_acc_leaves_idle, (in_valid_i && in_ready_o) |=> (state_q != S_IDLE))
  `OGM_NEVER(a_load_over_full, cmd.out_load && out_valid_q && !out_ready_i)
  `OGM_NEVER(a_idle_div_busy, (state_q == S_IDLE) && sts_i.div_busy)
endmodule

FILE: rtl/occupancy_grid_mapper.sv
// channel   dir  handshake                  payload
// in        in   in_valid_i / in_ready_o    in_data_i  (occgm_pkg::in_t)
// out       out  out_valid_o / out_ready_i  out_data_o (occgm_pkg::out_t)
// cfg       in   cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One request at a time. Set pose and unknown requests go from decode to the
// response. Add point and query wait on the 16-step shift-subtract cell divider.
// Clear: one map row written per cycle. Inflate: one row read per cycle on the
// plane's port while a row is gathered, then an accumulate and a write step.
// After reset a clearing pass over every map row runs with in_ready_o low.
// A finished result waits in the output register while the next request is taken.
module occupancy_grid_mapper #(
  parameter int unsigned GRID_COLS   = occgm_pkg::GRID_COLS_DEF,
  parameter int unsigned GRID_ROWS   = occgm_pkg::GRID_ROWS_DEF,
  parameter int unsigned MAX_INFLATE = occgm_pkg::MAX_INFLATE_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  occgm_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output occgm_pkg::out_t out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [2:0]      cfg_index_i,
  input  logic [15:0]     cfg_data_i
);
  import occgm_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  assign cfg_ready_o = 1'b1;

  occgm_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  occgm_dp #(
    .GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS), .MAX_INFLATE(MAX_INFLATE)
  ) u_dp (
    .clk_i, .rst_ni,
    .in_data_i,
    .cfg_we_i(cfg_valid_i && cfg_ready_o),
    .cfg_index_i, .cfg_data_i,
    .cmd_i(cmd), .sts_o(sts),
    .out_data_o
  );
endmodule
